@@ design/pfs_pkg.sv @@
`default_nettype none

package pfs_pkg;

	// Storage sizes.
	localparam int MAX_PIXELS      = 64;
	localparam int PALETTE_ENTRIES = 16;
	localparam int PIX_AW          = $clog2(MAX_PIXELS);
	localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
	localparam int GRID_DIM_MAX    = 8;

	// Field widths.
	localparam int CMD_W   = 3;
	localparam int COORD_W = 8;
	localparam int CI_W    = 8;
	localparam int COLOR_W = 32;
	localparam int KIND_W  = 2;
	localparam int POS_W   = 6;
	localparam int PV_W    = 4;
	localparam int DIM_W   = 4;
	localparam int LEN_W   = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_SET_PIXEL   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_READ_PIXEL  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FILL        = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SET_PALETTE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DRAW        = 3'd4;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_READBACK = 2'd0;
	localparam logic [KIND_W-1:0] KIND_STRIP    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SHOW     = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STRIP_LENGTH = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // latch the request fields and rewind the counter
		logic step;        // advance the pixel counter
		logic clr_wr;      // write zero at the counter address
		logic fill_wr;     // write the fill index at the counter address
		logic set_wr;      // write one pixel if it is in range
		logic pal_wr;      // write one palette entry if it is in range
		logic rd_pix;      // issue a pixel readback
		logic draw_issue;  // issue one scan position of a draw
		logic show_issue;  // issue the single show result
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic idx_full;    // counter at the last memory entry
		logic idx_last;    // counter at the last pixel in use
		logic fill_ok;     // fill index valid and grid not empty
		logic draw_empty;  // a draw emits no strip write
		logic pipe_busy;   // a result is still on its way out
	} ctrl_stat_t;

	// Palette contents after reset.
	function automatic logic [COLOR_W-1:0] palette_reset(input logic [PAL_AW-1:0] idx);
		logic [COLOR_W-1:0] val;
		unique case (idx)
			4'd1:    val = 32'h00FF_0000;
			4'd2:    val = 32'h0000_FF00;
			4'd3:    val = 32'h0000_00FF;
			4'd4:    val = 32'h00FF_FFFF;
			default: val = 32'h0000_0000;
		endcase
		return val;
	endfunction

endpackage

`default_nettype wire

@@ design/pfs_ctrl.sv @@
`default_nettype none

module pfs_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [pfs_pkg::CMD_W-1:0]  cmd,
	input  wire pfs_pkg::ctrl_stat_t        stat,
	output logic                            busy,
	output pfs_pkg::ctrl_cmd_t              ctl
);

	typedef enum logic [6:0] {
		ST_CLEAR   = 7'b0000001,
		ST_IDLE    = 7'b0000010,
		ST_SETPIX  = 7'b0000100,
		ST_READPIX = 7'b0001000,
		ST_SETPAL  = 7'b0010000,
		ST_FILL    = 7'b0100000,
		ST_DRAW    = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	// Busy while a sequence runs or a result is still in flight.
	assign busy   = (state_q != ST_IDLE) || stat.pipe_busy;
	assign accept = start && !busy;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ctl.clr_wr = 1'b1;
				ctl.step   = 1'b1;
				if (stat.idx_full) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					ctl.load = 1'b1;
					unique case (cmd)
						pfs_pkg::CMD_SET_PIXEL:   state_d = ST_SETPIX;
						pfs_pkg::CMD_READ_PIXEL:  state_d = ST_READPIX;
						pfs_pkg::CMD_FILL:        state_d = ST_FILL;
						pfs_pkg::CMD_SET_PALETTE: state_d = ST_SETPAL;
						pfs_pkg::CMD_DRAW:        state_d = ST_DRAW;
						default:                  state_d = ST_IDLE;
					endcase
				end
			end
			ST_SETPIX: begin
				ctl.set_wr = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_READPIX: begin
				ctl.rd_pix = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_SETPAL: begin
				ctl.pal_wr = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_FILL: begin
				if (!stat.fill_ok) begin
					state_d = ST_IDLE;
				end else begin
					ctl.fill_wr = 1'b1;
					ctl.step    = 1'b1;
					if (stat.idx_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_DRAW: begin
				if (stat.draw_empty) begin
					ctl.show_issue = 1'b1;
					state_d        = ST_IDLE;
				end else begin
					ctl.draw_issue = 1'b1;
					ctl.step       = 1'b1;
					if (stat.idx_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register; reset starts the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

@@ design/pfs_datapath.sv @@
`default_nettype none

module pfs_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire pfs_pkg::ctrl_cmd_t              ctl,
	output pfs_pkg::ctrl_stat_t                  stat,
	input  wire logic                            cfg_we,
	input  wire logic [pfs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [pfs_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic [pfs_pkg::COORD_W-1:0]     col,
	input  wire logic [pfs_pkg::COORD_W-1:0]     row,
	input  wire logic [pfs_pkg::CI_W-1:0]        color_index,
	input  wire logic [pfs_pkg::COLOR_W-1:0]     color_word,
	output logic                                 result_valid,
	output logic [pfs_pkg::KIND_W-1:0]           kind,
	output logic [pfs_pkg::POS_W-1:0]            strip_pos,
	output logic [pfs_pkg::COLOR_W-1:0]          led_color,
	output logic [pfs_pkg::PV_W-1:0]             pixel_value,
	output logic                                 last
);

	localparam logic [pfs_pkg::PIX_AW-1:0] PIX_LAST = pfs_pkg::PIX_AW'(pfs_pkg::MAX_PIXELS - 1);
	localparam logic [pfs_pkg::DIM_W-1:0]  DIM_MAX  = pfs_pkg::DIM_W'(pfs_pkg::GRID_DIM_MAX);

	// Configuration registers.
	logic [pfs_pkg::DIM_W-1:0] grid_width_q;
	logic [pfs_pkg::DIM_W-1:0] grid_height_q;
	logic [pfs_pkg::LEN_W-1:0] strip_length_q;

	// Latched request fields.
	logic [pfs_pkg::COORD_W-1:0] col_q;
	logic [pfs_pkg::COORD_W-1:0] row_q;
	logic [pfs_pkg::CI_W-1:0]    ci_q;
	logic [pfs_pkg::COLOR_W-1:0] cw_q;

	// Pixel counter, memories and read data.
	logic [pfs_pkg::PIX_AW-1:0]  idx_q;
	logic [pfs_pkg::PV_W-1:0]    pix_mem [pfs_pkg::MAX_PIXELS];
	logic [pfs_pkg::PV_W-1:0]    rd_q;
	logic [pfs_pkg::COLOR_W-1:0] palette_q [pfs_pkg::PALETTE_ENTRIES];

	// Derived grid values.
	logic [pfs_pkg::DIM_W-1:0]   w_eff;
	logic [pfs_pkg::DIM_W-1:0]   h_eff;
	logic [2*pfs_pkg::DIM_W-1:0] wh_full;
	logic [pfs_pkg::LEN_W-1:0]   wh;
	logic [pfs_pkg::LEN_W-1:0]   wh_m1;
	logic [pfs_pkg::LEN_W-1:0]   pos;
	logic [pfs_pkg::LEN_W-1:0]   cell_sum;
	logic [pfs_pkg::PIX_AW-1:0]  cell_addr;
	logic                        in_range;
	logic                        ci_ok;
	logic                        set_ok;
	logic                        emit;

	// Memory port selection.
	logic                        mem_we;
	logic [pfs_pkg::PIX_AW-1:0]  waddr;
	logic [pfs_pkg::PIX_AW-1:0]  raddr;
	logic [pfs_pkg::PV_W-1:0]    wdata;

	// Issue stage.
	logic                        v_s1;
	logic [pfs_pkg::KIND_W-1:0]  kind_s1;
	logic [pfs_pkg::POS_W-1:0]   pos_s1;
	logic                        last_s1;
	logic                        inrange_s1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q   <= DIM_MAX;
			grid_height_q  <= DIM_MAX;
			strip_length_q <= pfs_pkg::LEN_W'(pfs_pkg::MAX_PIXELS);
		end else if (cfg_we) begin
			unique case (cfg_index)
				pfs_pkg::CFG_GRID_WIDTH:   grid_width_q   <= cfg_data[pfs_pkg::DIM_W-1:0];
				pfs_pkg::CFG_GRID_HEIGHT:  grid_height_q  <= cfg_data[pfs_pkg::DIM_W-1:0];
				pfs_pkg::CFG_STRIP_LENGTH: strip_length_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Dimensions saturate at the grid maximum.
	assign w_eff   = (grid_width_q > DIM_MAX) ? DIM_MAX : grid_width_q;
	assign h_eff   = (grid_height_q > DIM_MAX) ? DIM_MAX : grid_height_q;
	assign wh_full = {{pfs_pkg::DIM_W{1'b0}}, w_eff} * {{pfs_pkg::DIM_W{1'b0}}, h_eff};
	assign wh      = wh_full[pfs_pkg::LEN_W-1:0];
	assign wh_m1   = wh - pfs_pkg::LEN_W'(1);

	// Scan position i maps to flipped strip position w*h-1-i.
	assign pos  = wh_m1 - {1'b0, idx_q};
	assign emit = pos < strip_length_q;

	// Single-pixel address and range check.
	assign in_range  = (col_q < {4'd0, w_eff}) && (row_q < {4'd0, h_eff});
	assign cell_sum  = ({4'd0, row_q[2:0]} * {3'd0, w_eff}) + {4'd0, col_q[2:0]};
	assign cell_addr = cell_sum[pfs_pkg::PIX_AW-1:0];
	assign ci_ok     = (ci_q[pfs_pkg::CI_W-1:pfs_pkg::PAL_AW] == '0);
	assign set_ok    = in_range && ci_ok;

	// Status toward the controller.
	always_comb begin
		stat            = '0;
		stat.idx_full   = (idx_q == PIX_LAST);
		stat.idx_last   = ({1'b0, idx_q} == wh_m1);
		stat.fill_ok    = ci_ok && (wh != '0);
		stat.draw_empty = (wh == '0) || (strip_length_q == '0);
		stat.pipe_busy  = v_s1;
	end

	// Request fields are latched on acceptance.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			col_q <= col;
			row_q <= row;
			ci_q  <= color_index;
			cw_q  <= color_word;
		end
	end

	// Pixel counter for the clearing pass, fill and draw.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (ctl.load) begin
			idx_q <= '0;
		end else if (ctl.step) begin
			idx_q <= idx_q + pfs_pkg::PIX_AW'(1);
		end
	end

	// Pixel memory port selection.
	assign mem_we = ctl.clr_wr || ctl.fill_wr || (ctl.set_wr && set_ok);
	assign waddr  = (ctl.clr_wr || ctl.fill_wr) ? idx_q : cell_addr;
	assign wdata  = ctl.clr_wr ? '0 : ci_q[pfs_pkg::PV_W-1:0];
	assign raddr  = ctl.draw_issue ? idx_q : cell_addr;

	// Pixel memory with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			pix_mem[waddr] <= wdata;
		end
		rd_q <= pix_mem[raddr];
	end

	// Palette table with its reset colors.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pfs_pkg::PALETTE_ENTRIES; i++) begin
				palette_q[pfs_pkg::PAL_AW'(i)] <= pfs_pkg::palette_reset(pfs_pkg::PAL_AW'(i));
			end
		end else if (ctl.pal_wr && ci_ok) begin
			palette_q[ci_q[pfs_pkg::PAL_AW-1:0]] <= cw_q;
		end
	end

	// Issue stage, aligned with the memory read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= ctl.rd_pix || ctl.show_issue || (ctl.draw_issue && emit);
		end
	end

	always_ff @(posedge clk) begin
		priority if (ctl.rd_pix) begin
			kind_s1 <= pfs_pkg::KIND_READBACK;
		end else if (ctl.show_issue) begin
			kind_s1 <= pfs_pkg::KIND_SHOW;
		end else begin
			kind_s1 <= pfs_pkg::KIND_STRIP;
		end
		pos_s1     <= pos[pfs_pkg::POS_W-1:0];
		last_s1    <= ctl.rd_pix || ctl.show_issue || (pos == '0);
		inrange_s1 <= in_range;
	end

	// Output register: palette lookup and field zeroing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		kind        <= kind_s1;
		last        <= last_s1;
		strip_pos   <= (kind_s1 == pfs_pkg::KIND_STRIP) ? pos_s1 : '0;
		led_color   <= (kind_s1 == pfs_pkg::KIND_STRIP) ? palette_q[rd_q] : '0;
		pixel_value <= ((kind_s1 == pfs_pkg::KIND_READBACK) && inrange_s1) ? rd_q : '0;
	end

endmodule

`default_nettype wire

@@ design/palette_framebuffer_flip_scanout.sv @@
// Channel   Ports                                          Handshake
// request   cmd, col, row, color_index, color_word         start high and busy low
// result    kind, strip_pos, led_color, pixel_value, last  result_valid, one cycle
// config    cfg_index, cfg_data                            cfg_we, no wait
//
// Set pixel, palette write and an ignored fill hold busy only for their own controller
// state; read pixel and a draw that only shows also hold it until their result is out.
// Fill and draw walk the w*h pixels one pixel a cycle through the counter and the pixel memory. An unknown
// command is taken without raising busy. Each result passes through the issue stage and
// the output register. After reset a clearing pass zeroes the 64-entry pixel memory
// while busy is high. Results cannot be stalled; each is shown for exactly one cycle.
`default_nettype none

module palette_framebuffer_flip_scanout (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [pfs_pkg::CMD_W-1:0]       cmd,
	input  wire logic [pfs_pkg::COORD_W-1:0]     col,
	input  wire logic [pfs_pkg::COORD_W-1:0]     row,
	input  wire logic [pfs_pkg::CI_W-1:0]        color_index,
	input  wire logic [pfs_pkg::COLOR_W-1:0]     color_word,
	input  wire logic                            cfg_we,
	input  wire logic [pfs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [pfs_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                                 result_valid,
	output logic [pfs_pkg::KIND_W-1:0]           kind,
	output logic [pfs_pkg::POS_W-1:0]            strip_pos,
	output logic [pfs_pkg::COLOR_W-1:0]          led_color,
	output logic [pfs_pkg::PV_W-1:0]             pixel_value,
	output logic                                 last
);

	pfs_pkg::ctrl_cmd_t  ctl;
	pfs_pkg::ctrl_stat_t stat;

	// Sequencer.
	pfs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.stat   (stat),
		.busy   (busy),
		.ctl    (ctl)
	);

	// Storage, address logic and result pipeline.
	pfs_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.stat         (stat),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.col          (col),
		.row          (row),
		.color_index  (color_index),
		.color_word   (color_word),
		.result_valid (result_valid),
		.kind         (kind),
		.strip_pos    (strip_pos),
		.led_color    (led_color),
		.pixel_value  (pixel_value),
		.last         (last)
	);

endmodule

`default_nettype wire

@@ verif/palette_framebuffer_flip_scanout_tb.sv @@
`timescale 1ns / 1ps

module palette_framebuffer_flip_scanout_tb;

	// Command codes the block must ignore.
	localparam logic [pfs_pkg::CMD_W-1:0] CMD_RESERVED_FIRST = pfs_pkg::CMD_DRAW + 1'b1;
	localparam logic [pfs_pkg::CMD_W-1:0] CMD_RESERVED_LAST  = '1;
	localparam int IDLE_LIMIT    = 1000;
	localparam int REPORT_LIMIT  = 10;
	localparam int PHASES        = 10;
	localparam int ITEMS_A_PHASE = 18;

	typedef struct packed {
		logic [pfs_pkg::CMD_W-1:0]   op;
		logic [pfs_pkg::COORD_W-1:0] x;
		logic [pfs_pkg::COORD_W-1:0] y;
		logic [pfs_pkg::CI_W-1:0]    ci;
		logic [pfs_pkg::COLOR_W-1:0] cw;
	} fb_request_t;

	typedef struct packed {
		logic [pfs_pkg::KIND_W-1:0]  kind;
		logic [pfs_pkg::POS_W-1:0]   pos;
		logic [pfs_pkg::COLOR_W-1:0] color;
		logic [pfs_pkg::PV_W-1:0]    pv;
		logic                        fin;
	} scan_result_t;

	typedef struct packed {
		bit                          is_cfg;
		bit                          typed;
		fb_request_t                 req;
		scan_result_t                want;
		logic [pfs_pkg::DIM_W-1:0]   cfg_w;
		logic [pfs_pkg::DIM_W-1:0]   cfg_h;
		logic [pfs_pkg::LEN_W-1:0]   cfg_len;
	} stim_row_t;

	localparam scan_result_t READ_ZERO =
		scan_result_t'({pfs_pkg::KIND_READBACK, {pfs_pkg::POS_W{1'b0}},
			{pfs_pkg::COLOR_W{1'b0}}, {pfs_pkg::PV_W{1'b0}}, 1'b1});
	localparam scan_result_t SHOW_ONLY =
		scan_result_t'({pfs_pkg::KIND_SHOW, {pfs_pkg::POS_W{1'b0}},
			{pfs_pkg::COLOR_W{1'b0}}, {pfs_pkg::PV_W{1'b0}}, 1'b1});

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           start = 1'b0;
	logic                           busy;
	logic [pfs_pkg::CMD_W-1:0]      cmd = '0;
	logic [pfs_pkg::COORD_W-1:0]    col = '0;
	logic [pfs_pkg::COORD_W-1:0]    row = '0;
	logic [pfs_pkg::CI_W-1:0]       color_index = '0;
	logic [pfs_pkg::COLOR_W-1:0]    color_word = '0;
	logic                           cfg_we = 1'b0;
	logic [pfs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [pfs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           result_valid;
	logic [pfs_pkg::KIND_W-1:0]     kind;
	logic [pfs_pkg::POS_W-1:0]      strip_pos;
	logic [pfs_pkg::COLOR_W-1:0]    led_color;
	logic [pfs_pkg::PV_W-1:0]       pixel_value;
	logic                           last;

	// Shadow copy of the framebuffer, palette and registers.
	logic [pfs_pkg::PV_W-1:0]    pixel_mem [pfs_pkg::MAX_PIXELS];
	logic [pfs_pkg::COLOR_W-1:0] palette_mem [pfs_pkg::PALETTE_ENTRIES];
	logic [pfs_pkg::DIM_W-1:0]   grid_w;
	logic [pfs_pkg::DIM_W-1:0]   grid_h;
	logic [pfs_pkg::LEN_W-1:0]   strip_len;

	scan_result_t pending_results [$];
	stim_row_t    stimulus_table [$];

	int fail_count = 0;
	int results_checked = 0;
	int requests_sent = 0;
	int draws_sent = 0;
	int settings_count = 0;
	int quiet_cycles = 0;
	int idle_pct = 31;

	palette_framebuffer_flip_scanout dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.col          (col),
		.row          (row),
		.color_index  (color_index),
		.color_word   (color_word),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.kind         (kind),
		.strip_pos    (strip_pos),
		.led_color    (led_color),
		.pixel_value  (pixel_value),
		.last         (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Width and height above the grid size saturate.
	function automatic int unsigned clamp_dim(input logic [pfs_pkg::DIM_W-1:0] v);
		return (v > pfs_pkg::GRID_DIM_MAX) ? pfs_pkg::GRID_DIM_MAX : int'(v);
	endfunction

	// Apply one request to the shadow state and queue the results it causes.
	function automatic void model_request(input fb_request_t req);
		int unsigned w;
		int unsigned h;
		int unsigned pos;
		int unsigned n;
		scan_result_t res;
		w = clamp_dim(grid_w);
		h = clamp_dim(grid_h);
		n = 0;
		case (req.op)
			pfs_pkg::CMD_SET_PIXEL: begin
				if (req.x < w && req.y < h && req.ci < pfs_pkg::PALETTE_ENTRIES)
					pixel_mem[pfs_pkg::PIX_AW'(req.y * w + req.x)] =
						req.ci[pfs_pkg::PV_W-1:0];
			end
			pfs_pkg::CMD_READ_PIXEL: begin
				res = READ_ZERO;
				if (req.x < w && req.y < h)
					res.pv = pixel_mem[pfs_pkg::PIX_AW'(req.y * w + req.x)];
				pending_results.push_back(res);
			end
			pfs_pkg::CMD_FILL: begin
				if (req.ci < pfs_pkg::PALETTE_ENTRIES)
					for (int unsigned i = 0; i < w * h; i++)
						pixel_mem[pfs_pkg::PIX_AW'(i)] = req.ci[pfs_pkg::PV_W-1:0];
			end
			pfs_pkg::CMD_SET_PALETTE: begin
				if (req.ci < pfs_pkg::PALETTE_ENTRIES)
					palette_mem[req.ci[pfs_pkg::PAL_AW-1:0]] = req.cw;
			end
			pfs_pkg::CMD_DRAW: begin
				// Rows then columns, position flipped in both axes.
				for (int unsigned yy = 0; yy < h; yy++) begin
					for (int unsigned xx = 0; xx < w; xx++) begin
						pos = (h - 1 - yy) * w + (w - 1 - xx);
						if (pos < strip_len) begin
							res = '0;
							res.kind = pfs_pkg::KIND_STRIP;
							res.pos = pos[pfs_pkg::POS_W-1:0];
							res.color = palette_mem[pixel_mem[pfs_pkg::PIX_AW'(yy * w + xx)]];
							pending_results.push_back(res);
							n++;
						end
					end
				end
				if (n == 0)
					pending_results.push_back(SHOW_ONLY);
				else
					pending_results[pending_results.size() - 1].fin = 1'b1;
			end
			default: ;
		endcase
	endfunction

	// Rows of the directed table.
	function automatic void add_request(input logic [pfs_pkg::CMD_W-1:0] op, input int x,
			input int y, input int ci, input logic [pfs_pkg::COLOR_W-1:0] cw);
		stim_row_t r;
		r = '0;
		r.req = {op, pfs_pkg::COORD_W'(x), pfs_pkg::COORD_W'(y), pfs_pkg::CI_W'(ci), cw};
		stimulus_table.push_back(r);
	endfunction

	function automatic void add_typed(input logic [pfs_pkg::CMD_W-1:0] op, input int x,
			input int y, input scan_result_t want);
		stim_row_t r;
		r = '0;
		r.typed = 1'b1;
		r.req = {op, pfs_pkg::COORD_W'(x), pfs_pkg::COORD_W'(y), {pfs_pkg::CI_W{1'b0}},
			{pfs_pkg::COLOR_W{1'b0}}};
		r.want = want;
		stimulus_table.push_back(r);
	endfunction

	function automatic void add_settings(input int w, input int h, input int len);
		stim_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.cfg_w = pfs_pkg::DIM_W'(w);
		r.cfg_h = pfs_pkg::DIM_W'(h);
		r.cfg_len = pfs_pkg::LEN_W'(len);
		stimulus_table.push_back(r);
	endfunction

	// Random request: mostly well-formed for the current grid, the rest noise.
	function automatic fb_request_t random_request();
		fb_request_t req;
		int unsigned w;
		int unsigned h;
		int unsigned r;
		w = clamp_dim(grid_w);
		h = clamp_dim(grid_h);
		r = $urandom_range(99);
		req.op = pfs_pkg::CMD_W'($urandom_range(CMD_RESERVED_LAST));
		req.x = pfs_pkg::COORD_W'($urandom_range(255));
		req.y = pfs_pkg::COORD_W'($urandom_range(255));
		req.ci = pfs_pkg::CI_W'($urandom_range(255));
		req.cw = $urandom();
		if (r < 12)
			return req;
		if (r < 47)
			req.op = pfs_pkg::CMD_SET_PIXEL;
		else if (r < 67)
			req.op = pfs_pkg::CMD_READ_PIXEL;
		else if (r < 80)
			req.op = pfs_pkg::CMD_SET_PALETTE;
		else if (r < 88)
			req.op = pfs_pkg::CMD_FILL;
		else
			req.op = pfs_pkg::CMD_DRAW;
		if ($urandom_range(99) >= 15) begin
			req.ci = pfs_pkg::CI_W'($urandom_range(pfs_pkg::PALETTE_ENTRIES - 1));
			if (w != 0 && h != 0) begin
				req.x = pfs_pkg::COORD_W'($urandom_range(w - 1));
				req.y = pfs_pkg::COORD_W'($urandom_range(h - 1));
			end
		end
		return req;
	endfunction

	// Hand one request over and record what it should produce.
	task automatic send_request(input fb_request_t req, input bit typed,
			input scan_result_t want);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= req.op;
		col <= req.x;
		row <= req.y;
		color_index <= req.ci;
		color_word <= req.cw;
		do
			@(posedge clk);
		while (busy);
		if (typed)
			pending_results.push_back(want);
		else
			model_request(req);
		requests_sent++;
		if (req.op == pfs_pkg::CMD_DRAW)
			draws_sent++;
	endtask

	// Stop sending and wait until every queued result has come back.
	task automatic drain_results();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	// Registers change only once the block has gone fully quiet.
	task automatic write_settings(input logic [pfs_pkg::DIM_W-1:0] w,
			input logic [pfs_pkg::DIM_W-1:0] h, input logic [pfs_pkg::LEN_W-1:0] len);
		drain_results();
		while (busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= pfs_pkg::CFG_GRID_WIDTH;
		cfg_data <= {3'($urandom_range(7)), w};
		@(posedge clk);
		cfg_index <= pfs_pkg::CFG_GRID_HEIGHT;
		cfg_data <= {3'($urandom_range(7)), h};
		@(posedge clk);
		cfg_index <= pfs_pkg::CFG_STRIP_LENGTH;
		cfg_data <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
		grid_w = w;
		grid_h = h;
		strip_len = len;
		settings_count++;
	endtask

	// Check every result against the oldest expectation; also the watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid || (start && !busy))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("timeout: nothing moved for %0d cycles", IDLE_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
			if (result_valid) begin
				if (pending_results.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("%0t: unexpected result kind %0d pos %0d color %h value %0d last %0d",
							$realtime, kind, strip_pos, led_color, pixel_value, last);
				end else begin
					scan_result_t exp;
					exp = pending_results.pop_front();
					results_checked++;
					if (kind !== exp.kind || strip_pos !== exp.pos || led_color !== exp.color ||
							pixel_value !== exp.pv || last !== exp.fin) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT) begin
							$display("%0t: mismatch, expected kind %0d pos %0d color %h value %0d last %0d",
								$realtime, exp.kind, exp.pos, exp.color, exp.pv, exp.fin);
							$display("    got kind %0d pos %0d color %h value %0d last %0d",
								kind, strip_pos, led_color, pixel_value, last);
						end
					end
				end
			end
		end
	end

	// Stimulus: directed table first, then random phases.
	initial begin
		stim_row_t r;
		fb_request_t req;
		int counted;
		int unsigned w;
		logic [pfs_pkg::DIM_W-1:0] pw;
		logic [pfs_pkg::DIM_W-1:0] ph;
		logic [pfs_pkg::LEN_W-1:0] plen;

		for (int i = 0; i < pfs_pkg::MAX_PIXELS; i++)
			pixel_mem[pfs_pkg::PIX_AW'(i)] = '0;
		for (int i = 0; i < pfs_pkg::PALETTE_ENTRIES; i++)
			palette_mem[pfs_pkg::PAL_AW'(i)] = '0;
		palette_mem[1] = 32'h00FF_0000;
		palette_mem[2] = 32'h0000_FF00;
		palette_mem[3] = 32'h0000_00FF;
		palette_mem[4] = 32'h00FF_FFFF;
		grid_w = 4'd8;
		grid_h = 4'd8;
		strip_len = 7'd64;

		// Grid cleared at reset, edges of every field, ignored writes.
		add_typed(pfs_pkg::CMD_READ_PIXEL, 0, 0, READ_ZERO);
		add_request(pfs_pkg::CMD_DRAW, 0, 0, 0, '0);
		add_request(pfs_pkg::CMD_SET_PIXEL, 0, 0, 15, '0);
		add_request(pfs_pkg::CMD_SET_PIXEL, 7, 7, 4, 32'hFFFF_FFFF);
		add_request(pfs_pkg::CMD_SET_PIXEL, 3, 5, 2, '0);
		add_request(pfs_pkg::CMD_SET_PIXEL, 8, 0, 1, '0);
		add_request(pfs_pkg::CMD_SET_PIXEL, 1, 1, 16, '0);
		add_request(pfs_pkg::CMD_SET_PIXEL, 255, 255, 255, 32'hFFFF_FFFF);
		add_request(pfs_pkg::CMD_READ_PIXEL, 0, 0, 0, '0);
		add_request(pfs_pkg::CMD_READ_PIXEL, 7, 7, 0, '0);
		add_typed(pfs_pkg::CMD_READ_PIXEL, 255, 255, READ_ZERO);
		add_request(pfs_pkg::CMD_SET_PALETTE, 0, 0, 15, 32'hFFFF_FFFF);
		add_request(pfs_pkg::CMD_SET_PALETTE, 0, 0, 16, 32'h1234_5678);
		add_request(pfs_pkg::CMD_SET_PALETTE, 0, 0, 2, 32'h00A5_5A00);
		add_request(pfs_pkg::CMD_DRAW, 0, 0, 0, '0);
		add_request(CMD_RESERVED_FIRST, 1, 1, 1, '0);
		add_request(CMD_RESERVED_LAST, 255, 255, 255, 32'hFFFF_FFFF);
		add_request(pfs_pkg::CMD_FILL, 0, 0, 255, '0);
		add_request(pfs_pkg::CMD_FILL, 0, 0, 15, '0);
		// Small grid with a short strip, then a strip of zero length.
		add_settings(3, 2, 4);
		add_request(pfs_pkg::CMD_SET_PIXEL, 2, 1, 1, '0);
		add_request(pfs_pkg::CMD_DRAW, 0, 0, 0, '0);
		add_settings(3, 2, 0);
		add_typed(pfs_pkg::CMD_DRAW, 0, 0, SHOW_ONLY);
		// Empty grid: reads give zero and a draw only shows.
		add_settings(0, 8, 64);
		add_typed(pfs_pkg::CMD_READ_PIXEL, 0, 0, READ_ZERO);
		add_typed(pfs_pkg::CMD_DRAW, 0, 0, SHOW_ONLY);
		// Oversized registers saturate to the full grid.
		add_settings(15, 1, 127);
		add_request(pfs_pkg::CMD_DRAW, 0, 0, 0, '0);
		add_settings(8, 8, 64);
		add_request(pfs_pkg::CMD_DRAW, 0, 0, 0, '0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stimulus_table[i]) begin
			r = stimulus_table[i];
			if (r.is_cfg)
				write_settings(r.cfg_w, r.cfg_h, r.cfg_len);
			else
				send_request(r.req, r.typed, r.want);
		end

		// Random phases, each under its own register setting.
		for (int p = 0; p < PHASES; p++) begin
			if (p == 0) begin
				pw = 4'd8; ph = 4'd8; plen = 7'd64;
			end else if (p == 1) begin
				pw = 4'd1; ph = 4'd1; plen = 7'd1;
			end else if (p == PHASES - 1) begin
				pw = 4'd15; ph = 4'd15; plen = 7'd127;
			end else begin
				w = $urandom_range(99);
				pw = (w < 6) ? 4'd0 : (w < 16) ? 4'($urandom_range(15, 9)) :
					4'($urandom_range(8, 1));
				ph = 4'($urandom_range(8, 1));
				if ($urandom_range(1) == 0)
					plen = pfs_pkg::LEN_W'($urandom_range(127));
				else
					plen = pfs_pkg::LEN_W'($urandom_range(clamp_dim(pw) * clamp_dim(ph)));
			end
			write_settings(pw, ph, plen);
			idle_pct = (p == 3) ? 0 : 31;
			counted = 0;
			while (counted < ITEMS_A_PHASE) begin
				req = random_request();
				send_request(req, 1'b0, READ_ZERO);
				if (req.op <= pfs_pkg::CMD_DRAW)
					counted++;
				// Once, hold off until a full draw has come back.
				if (p == 4 && counted == 10) begin
					req.op = pfs_pkg::CMD_DRAW;
					send_request(req, 1'b0, READ_ZERO);
					counted++;
					drain_results();
				end
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		$display("Ran %0d requests, %0d of them draws, under %0d register settings.",
			requests_sent, draws_sent, settings_count);
		$display("Checked %0d results; %0d failures.", results_checked, fail_count);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
